>>> rtl/plldnr_pkg.sv
// ----------------------------------------------------------------------------
// plldnr_pkg: PLL divider nearest-rate lookup package
// Shared widths, types, search FSM states and the two constant PMS tables.
// ----------------------------------------------------------------------------
package plldnr_pkg;

   localparam int STORED_ENTRIES    = 45;
   localparam int TABLE_DEPTH_DEF   = 45;

   localparam int IDX_W  = 6;
   localparam int KHZ_W  = 21;
   localparam int TGT_W  = 22;
   localparam int P_W    = 6;
   localparam int M_W    = 10;
   localparam int S_W    = 3;
   localparam int WORD_W = 32;

   localparam int S_POS  = 0;
   localparam int M_POS  = 8;
   localparam int P_POS  = 18;
   localparam int PD_POS = 29;

   typedef struct packed {
      logic [KHZ_W-1:0] khz;
      logic [P_W-1:0]   p;
      logic [M_W-1:0]   m;
      logic [S_W-1:0]   s;
   } pms_entry_type;

   // start request from the top level to the search unit
   typedef struct packed {
      logic             start;
      logic             high_tab;
      logic [TGT_W-1:0] target;
   } plldnr_req_type;

   // completion status back from the search unit
   typedef struct packed {
      logic             done;
      logic [IDX_W-1:0] index;
   } plldnr_res_type;

   typedef enum logic [2:0] {
      SRCH_IDLE,
      SRCH_STEP,
      SRCH_GAP_HI,
      SRCH_GAP_LO,
      SRCH_DONE
   } plldnr_state_type;

   function automatic pms_entry_type mk(input int khz, input int p, input int m, input int s);
      pms_entry_type e;
      e.khz = KHZ_W'(khz);
      e.p   = P_W'(p);
      e.m   = M_W'(m);
      e.s   = S_W'(s);
      return e;
   endfunction

   // table for PLL 0 and 1, descending rate
   function automatic pms_entry_type low_entry(input logic [IDX_W-1:0] idx);
      pms_entry_type e;
      case (idx)
         6'd0:  e = mk(2000000, 6, 500, 0);
         6'd1:  e = mk(1900000, 6, 475, 0);
         6'd2:  e = mk(1800000, 4, 300, 0);
         6'd3:  e = mk(1700000, 6, 425, 0);
         6'd4:  e = mk(1600000, 3, 400, 1);
         6'd5:  e = mk(1500000, 3, 375, 1);
         6'd6:  e = mk(1400000, 3, 350, 1);
         6'd7:  e = mk(1300000, 3, 325, 1);
         6'd8:  e = mk(1200000, 3, 300, 1);
         6'd9:  e = mk(1100000, 6, 550, 1);
         6'd10: e = mk(1000000, 6, 500, 1);
         6'd11: e = mk(900000,  4, 300, 1);
         6'd12: e = mk(800000,  6, 400, 1);
         6'd13: e = mk(780000,  4, 260, 1);
         6'd14: e = mk(760000,  6, 380, 1);
         6'd15: e = mk(740000,  6, 370, 1);
         6'd16: e = mk(720000,  4, 240, 1);
         6'd17: e = mk(562000,  6, 562, 2);
         6'd18: e = mk(533000,  6, 533, 2);
         6'd19: e = mk(490000,  6, 490, 2);
         6'd20: e = mk(470000,  6, 470, 2);
         6'd21: e = mk(460000,  6, 460, 2);
         6'd22: e = mk(450000,  4, 300, 2);
         6'd23: e = mk(440000,  6, 440, 2);
         6'd24: e = mk(430000,  6, 430, 2);
         6'd25: e = mk(420000,  4, 280, 2);
         6'd26: e = mk(410000,  6, 410, 2);
         6'd27: e = mk(400000,  6, 400, 2);
         6'd28: e = mk(399000,  4, 266, 2);
         6'd29: e = mk(390000,  4, 260, 2);
         6'd30: e = mk(384000,  4, 256, 2);
         6'd31: e = mk(350000,  6, 350, 2);
         6'd32: e = mk(330000,  4, 220, 2);
         6'd33: e = mk(300000,  4, 400, 3);
         6'd34: e = mk(266000,  6, 532, 3);
         6'd35: e = mk(250000,  6, 500, 3);
         6'd36: e = mk(220000,  6, 440, 3);
         6'd37: e = mk(200000,  6, 400, 3);
         6'd38: e = mk(166000,  6, 332, 3);
         6'd39: e = mk(147500,  6, 590, 4);
         6'd40: e = mk(133000,  6, 532, 4);
         6'd41: e = mk(125000,  6, 500, 4);
         6'd42: e = mk(100000,  6, 400, 4);
         6'd43: e = mk(96000,   4, 256, 4);
         6'd44: e = mk(48000,   3, 96,  4);
         default: e = mk(0, 0, 0, 0);
      endcase
      return e;
   endfunction

   // table for PLL 2 and 3, descending rate
   function automatic pms_entry_type high_entry(input logic [IDX_W-1:0] idx);
      pms_entry_type e;
      case (idx)
         6'd0:  e = mk(2000000, 3, 250, 0);
         6'd1:  e = mk(1900000, 4, 317, 0);
         6'd2:  e = mk(1800000, 3, 225, 0);
         6'd3:  e = mk(1700000, 4, 283, 0);
         6'd4:  e = mk(1600000, 3, 200, 0);
         6'd5:  e = mk(1500000, 4, 250, 0);
         6'd6:  e = mk(1400000, 3, 175, 0);
         6'd7:  e = mk(1300000, 4, 217, 0);
         6'd8:  e = mk(1200000, 3, 150, 0);
         6'd9:  e = mk(1100000, 3, 275, 1);
         6'd10: e = mk(1000000, 3, 250, 1);
         6'd11: e = mk(900000,  3, 225, 1);
         6'd12: e = mk(800000,  3, 200, 1);
         6'd13: e = mk(780000,  3, 195, 1);
         6'd14: e = mk(760000,  3, 190, 1);
         6'd15: e = mk(740000,  3, 185, 1);
         6'd16: e = mk(720000,  3, 180, 1);
         6'd17: e = mk(562000,  4, 187, 1);
         6'd18: e = mk(533000,  4, 355, 2);
         6'd19: e = mk(490000,  3, 245, 2);
         6'd20: e = mk(470000,  3, 235, 2);
         6'd21: e = mk(460000,  3, 230, 2);
         6'd22: e = mk(450000,  3, 225, 2);
         6'd23: e = mk(440000,  3, 220, 2);
         6'd24: e = mk(430000,  3, 215, 2);
         6'd25: e = mk(420000,  3, 210, 2);
         6'd26: e = mk(410000,  3, 205, 2);
         6'd27: e = mk(400000,  3, 200, 2);
         6'd28: e = mk(399000,  4, 266, 2);
         6'd29: e = mk(390000,  3, 195, 2);
         6'd30: e = mk(384000,  3, 192, 2);
         6'd31: e = mk(350000,  3, 175, 2);
         6'd32: e = mk(330000,  3, 165, 2);
         6'd33: e = mk(300000,  3, 150, 2);
         6'd34: e = mk(266000,  3, 266, 3);
         6'd35: e = mk(250000,  3, 250, 3);
         6'd36: e = mk(220000,  3, 220, 3);
         6'd37: e = mk(200000,  3, 200, 3);
         6'd38: e = mk(166000,  3, 166, 3);
         6'd39: e = mk(147500,  3, 147, 3);
         6'd40: e = mk(133000,  3, 266, 4);
         6'd41: e = mk(125000,  3, 250, 4);
         6'd42: e = mk(100000,  3, 200, 4);
         6'd43: e = mk(96000,   3, 192, 4);
         6'd44: e = mk(48000,   3, 96,  4);
         default: e = mk(0, 0, 0, 0);
      endcase
      return e;
   endfunction

   function automatic pms_entry_type pms_lookup(input logic high_tab,
                                                input logic [IDX_W-1:0] idx);
      pms_entry_type lo_e;
      pms_entry_type hi_e;
      lo_e = low_entry(idx);
      hi_e = high_entry(idx);
      return high_tab ? hi_e : lo_e;
   endfunction

endpackage

>>> rtl/plldnr_search.sv
// ----------------------------------------------------------------------------
// plldnr_search: binary search for the nearest table rate
// One table read port and one subtractor, reused for the bisection compares
// and for the two neighbor gaps.
// ----------------------------------------------------------------------------
module plldnr_search #(
   parameter int TABLE_DEPTH = plldnr_pkg::TABLE_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  plldnr_pkg::plldnr_req_type req,
   output plldnr_pkg::plldnr_res_type res
);

   localparam int EFF_DEPTH = (TABLE_DEPTH > plldnr_pkg::STORED_ENTRIES) ?
                              plldnr_pkg::STORED_ENTRIES :
                              ((TABLE_DEPTH < 1) ? 1 : TABLE_DEPTH);
   localparam int IW = plldnr_pkg::IDX_W;
   localparam int TW = plldnr_pkg::TGT_W;
   localparam logic [IW-1:0] DEPTH = IW'(EFF_DEPTH);
   localparam logic [IW-1:0] LAST  = IW'(EFF_DEPTH - 1);

   plldnr_pkg::plldnr_state_type state_ff, state_in;

   logic [IW-1:0] lo_ff, lo_in;      // count of entries known above target
   logic [IW-1:0] hi_ff, hi_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [TW-1:0] tgt_ff, tgt_in;
   logic [TW-1:0] gap_ff, gap_in;
   logic          tab_ff, tab_in;

   logic [IW:0]   mid_sum;
   logic [IW-1:0] mid;
   logic [IW-1:0] rd_addr;
   plldnr_pkg::pms_entry_type rd_entry;
   logic [TW:0]   sub_a, sub_b, sub_d;
   logic          entry_above;

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[IW:1];

   // single table read port
   assign rd_entry = plldnr_pkg::pms_lookup(tab_ff, rd_addr);

   // shared subtractor; borrow out flags entry rate above target
   assign sub_d       = sub_a - sub_b;
   assign entry_above = sub_d[TW];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         plldnr_pkg::SRCH_IDLE: begin
            if (req.start) state_in = plldnr_pkg::SRCH_STEP;
         end
         plldnr_pkg::SRCH_STEP: begin
            if (lo_ff == hi_ff) begin
               if (lo_ff == '0 || lo_ff == DEPTH) state_in = plldnr_pkg::SRCH_DONE;
               else                               state_in = plldnr_pkg::SRCH_GAP_HI;
            end
         end
         plldnr_pkg::SRCH_GAP_HI: state_in = plldnr_pkg::SRCH_GAP_LO;
         plldnr_pkg::SRCH_GAP_LO: state_in = plldnr_pkg::SRCH_DONE;
         plldnr_pkg::SRCH_DONE:   state_in = plldnr_pkg::SRCH_IDLE;
         default:                 state_in = plldnr_pkg::SRCH_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      lo_in   = lo_ff;
      hi_in   = hi_ff;
      idx_in  = idx_ff;
      tgt_in  = tgt_ff;
      gap_in  = gap_ff;
      tab_in  = tab_ff;
      rd_addr = mid;
      sub_a   = {1'b0, tgt_ff};
      sub_b   = {2'b0, rd_entry.khz};
      res     = '0;
      unique case (state_ff)
         plldnr_pkg::SRCH_IDLE: begin
            if (req.start) begin
               lo_in  = '0;
               hi_in  = DEPTH;
               tgt_in = req.target;
               tab_in = req.high_tab;
            end
         end
         plldnr_pkg::SRCH_STEP: begin
            if (lo_ff != hi_ff) begin
               if (entry_above) lo_in = mid + IW'(1);
               else             hi_in = mid;
            end else if (lo_ff == '0) begin
               idx_in = '0;
            end else if (lo_ff == DEPTH) begin
               idx_in = LAST;
            end
         end
         plldnr_pkg::SRCH_GAP_HI: begin
            // upper neighbor: rate minus target, always positive
            rd_addr = lo_ff - IW'(1);
            sub_a   = {2'b0, rd_entry.khz};
            sub_b   = {1'b0, tgt_ff};
            gap_in  = sub_d[TW-1:0];
         end
         plldnr_pkg::SRCH_GAP_LO: begin
            // lower neighbor wins only when strictly closer
            rd_addr = lo_ff;
            if (sub_d[TW-1:0] < gap_ff) idx_in = lo_ff;
            else                        idx_in = lo_ff - IW'(1);
         end
         plldnr_pkg::SRCH_DONE: begin
            res.done  = 1'b1;
            res.index = idx_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= plldnr_pkg::SRCH_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      idx_ff <= idx_in;
      tgt_ff <= tgt_in;
      gap_ff <= gap_in;
      tab_ff <= tab_in;
   end

endmodule

>>> rtl/pll_divider_nearest_rate_lookup_core.sv
// ----------------------------------------------------------------------------
// pll_divider_nearest_rate_lookup_core: nearest PLL rate lookup
// Returns the PMS table entry closest to a requested frequency.
// ----------------------------------------------------------------------------
// One request beat carries a PLL number and a target rate in kHz; one response
// beat returns the nearest entry of the matching PMS table (PLL 0/1 or 2/3):
// its index, rate, P, M, S and the setting word with power-down set. Exact
// rates match, a tie picks the higher rate, and targets beyond either end
// clamp to the first or last entry. The block handles one request at a time:
// req_ready is low from acceptance until the response beat is taken. A lookup
// is a binary search over a single table read port and one shared subtractor:
// five or six halving steps for 45 entries, one settle step, two gap steps
// unless the target lies off either end of the table, and one finish step.
// The response sits in an output register until taken.
module pll_divider_nearest_rate_lookup_core #(
   parameter int TABLE_DEPTH = plldnr_pkg::TABLE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_pll_select,
   input  logic [plldnr_pkg::TGT_W-1:0]      req_target_khz,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [plldnr_pkg::IDX_W-1:0]      rsp_entry_index,
   output logic [plldnr_pkg::KHZ_W-1:0]      rsp_real_khz,
   output logic [plldnr_pkg::P_W-1:0]        rsp_pre_divider,
   output logic [plldnr_pkg::M_W-1:0]        rsp_main_multiplier,
   output logic [plldnr_pkg::S_W-1:0]        rsp_post_scaler,
   output logic [plldnr_pkg::WORD_W-1:0]     rsp_pll_setting_word
);

   logic busy_ff, busy_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic                          tab_ff, tab_in;
   logic [plldnr_pkg::IDX_W-1:0]  idx_ff, idx_in;
   logic [plldnr_pkg::KHZ_W-1:0]  khz_ff, khz_in;
   logic [plldnr_pkg::P_W-1:0]    p_ff, p_in;
   logic [plldnr_pkg::M_W-1:0]    m_ff, m_in;
   logic [plldnr_pkg::S_W-1:0]    s_ff, s_in;
   logic [plldnr_pkg::WORD_W-1:0] word_ff, word_in;

   logic req_fire, rsp_fire;
   plldnr_pkg::plldnr_req_type srch_req;
   plldnr_pkg::plldnr_res_type srch_res;
   plldnr_pkg::pms_entry_type  pick;

   assign req_ready = !busy_ff;
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid_ff && rsp_ready;

   // PLL 2 and 3 use the second table
   assign srch_req.start    = req_fire;
   assign srch_req.high_tab = req_pll_select[1];
   assign srch_req.target   = req_target_khz;

   plldnr_search #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_search (
      .clock (clock),
      .reset (reset),
      .req   (srch_req),
      .res   (srch_res)
   );

   // table select kept from the request beat; re-read the chosen entry here
   assign pick = plldnr_pkg::pms_lookup(tab_ff, srch_res.index);

   // busy spans acceptance through the response beat
   always_comb begin
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      if (req_fire)      busy_in      = 1'b1;
      if (srch_res.done) rsp_valid_in = 1'b1;
      if (rsp_fire) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b0;
      end
   end

   // response payload capture
   always_comb begin
      tab_in  = tab_ff;
      idx_in  = idx_ff;
      khz_in  = khz_ff;
      p_in    = p_ff;
      m_in    = m_ff;
      s_in    = s_ff;
      word_in = word_ff;
      if (req_fire) tab_in = req_pll_select[1];
      if (srch_res.done) begin
         idx_in  = srch_res.index;
         khz_in  = pick.khz;
         p_in    = pick.p;
         m_in    = pick.m;
         s_in    = pick.s;
         word_in = (plldnr_pkg::WORD_W'(1) << plldnr_pkg::PD_POS)
                 | (plldnr_pkg::WORD_W'(pick.s) << plldnr_pkg::S_POS)
                 | (plldnr_pkg::WORD_W'(pick.m) << plldnr_pkg::M_POS)
                 | (plldnr_pkg::WORD_W'(pick.p) << plldnr_pkg::P_POS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tab_ff  <= tab_in;
      idx_ff  <= idx_in;
      khz_ff  <= khz_in;
      p_ff    <= p_in;
      m_ff    <= m_in;
      s_ff    <= s_in;
      word_ff <= word_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_entry_index      = idx_ff;
   assign rsp_real_khz         = khz_ff;
   assign rsp_pre_divider      = p_ff;
   assign rsp_main_multiplier  = m_ff;
   assign rsp_post_scaler      = s_ff;
   assign rsp_pll_setting_word = word_ff;

`ifndef SYNTH
   // never take a new request while a response is pending
   a_no_accept_while_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !req_ready)
      else $error("request accepted with response pending");

   // search completes only for an accepted request with no response waiting
   a_done_when_busy: assert property (@(posedge clock) disable iff (reset)
      srch_res.done |-> (busy_ff && !rsp_valid_ff))
      else $error("search finished with no request outstanding");

   // an accepted request starts a lookup, so no response in the next cycle
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !rsp_valid_ff)
      else $error("response appeared without a search");

   // setting word always has power-down set and mirrors P, M, S
   a_word_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (word_ff[plldnr_pkg::PD_POS] && word_ff[7:0] == 8'(s_ff)
                        && word_ff[17:8] == m_ff && word_ff[23:18] == p_ff))
      else $error("setting word does not match P, M, S");
`endif

endmodule
